FILE: rtl/core/pdr_pkg.sv
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types and codes for the Paxos decision role core: phase, command,
// message and register codes, and the state and result records.
// ----------------------------------------------------------------------------
package pdr_pkg;

    // Field types
    typedef logic signed [15:0] ballot_t;
    typedef logic signed [31:0] value_t;
    typedef logic [2:0]         phase_t;
    typedef logic [2:0]         cmd_t;
    typedef logic [1:0]         msg_t;
    typedef logic [7:0]         node_t;
    typedef logic [6:0]         count_t;
    typedef logic [1:0]         cfg_idx_t;

    // Number of nodes in the group; a strict majority decides
    localparam logic [7:0] NODE_COUNT = 8'd5;

    localparam ballot_t BALLOT_NONE  = 16'sh FFFF;
    localparam ballot_t BALLOT_MAX   = 16'sh 7FFF;
    localparam value_t  VALUE_NONE   = 32'sh FFFF_FFFF;
    localparam count_t  COUNT_MAX    = 7'h7F;

    // Phase codes
    localparam phase_t PH_INIT         = 3'd0;
    localparam phase_t PH_WAIT_PREPARE = 3'd1;
    localparam phase_t PH_WAIT_PROMISE = 3'd2;
    localparam phase_t PH_WAIT_ACCEPT  = 3'd3;
    localparam phase_t PH_DECIDED      = 3'd4;

    // Command codes
    localparam cmd_t CMD_PREPARE = 3'd0;
    localparam cmd_t CMD_PROMISE = 3'd1;
    localparam cmd_t CMD_ACCEPT  = 3'd2;
    localparam cmd_t CMD_ACK     = 3'd3;
    localparam cmd_t CMD_TIMEOUT = 3'd4;
    localparam cmd_t CMD_CLIENT  = 3'd5;

    // Outgoing message types
    localparam msg_t MSG_PREPARE = 2'd0;
    localparam msg_t MSG_PROMISE = 2'd1;
    localparam msg_t MSG_ACCEPT  = 2'd2;

    // Register indexes (node id and slot belong to the transport, not kept)
    localparam cfg_idx_t CFG_ROLE      = 2'd0;
    localparam cfg_idx_t CFG_LEADER_ID = 2'd2;

    // Role values
    localparam logic ROLE_ACCEPTOR = 1'b1;

    // Decision state
    typedef struct packed {
        phase_t  phase;
        ballot_t ballot;
        value_t  decision_value;
        ballot_t promised_ballot;
        value_t  promised_value;
        count_t  promise_count;
    } pdr_state_t;

    // Configuration seen by the step logic
    typedef struct packed {
        logic  role;
        node_t leader_id;
    } pdr_cfg_t;

    // One result item
    typedef struct packed {
        logic    send_valid;
        msg_t    send_type;
        logic    send_to_all;
        node_t   send_dest;
        ballot_t send_ballot;
        value_t  send_value;
        phase_t  phase_now;
        ballot_t chosen_ballot;
        value_t  chosen_value;
    } pdr_result_t;

endpackage

FILE: rtl/core/paxos_decision_role_fsm_core.sv
// ----------------------------------------------------------------------------
// paxos_decision_role_fsm_core
// One Paxos decision instance for a proposer or acceptor node.
//
//   channel  dir  signals                      item
//   s_*      in   tvalid tready tdata tuser    message or client value
//   m_*      out  tvalid tready tdata tuser    sent message and decision
//   cfg_*    in   we index wdata               register write
//
// One item per cycle sustained while m_tready is high; an item passes the input
// register, then the step logic into the result register. The state loop closes
// through pdr_step combinationally, so items follow back to back.
// Reset clears the decision state to init and the cfg and valid registers to zero.
// A stalled result holds in the result register; the input register takes
// one more item meanwhile, then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module paxos_decision_role_fsm_core
    import pdr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // cfg
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // msg_ballot[15:0], msg_value[47:16]
    input  logic [2:0]   s_tuser,   // cmd[2:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // send_dest[7:0], send_ballot[23:8], send_value[55:24], phase_now[58:56],
    // chosen_ballot[74:59], chosen_value[106:75], zero fill[111:107]
    output logic [111:0] m_tdata,
    // send_valid[0], send_type[2:1], send_to_all[3]
    output logic [3:0]   m_tuser
);

    logic        role_reg;
    node_t       leader_reg;

    logic        in_valid_reg, in_valid_next;
    cmd_t        in_cmd_reg;
    ballot_t     in_ballot_reg;
    value_t      in_value_reg;

    pdr_state_t  st_reg;
    pdr_state_t  st_next;
    pdr_result_t step_res;
    pdr_result_t out_reg;
    logic        out_valid_reg, out_valid_next;

    pdr_cfg_t    cfg;
    logic        out_free;
    logic        step_go;
    logic        in_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg   <= 1'b0;
            leader_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROLE:      role_reg   <= cfg_wdata[0];
                CFG_LEADER_ID: leader_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    assign cfg.role      = role_reg;
    assign cfg.leader_id = leader_reg;

    // Handshake control
    assign out_free       = !out_valid_reg || m_tready;
    assign step_go        = in_valid_reg && out_free;
    assign s_tready       = !in_valid_reg || out_free;
    assign in_take        = s_tvalid && s_tready;
    assign in_valid_next  = in_take ? 1'b1 : (step_go ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_go ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg    <= s_tuser;
            in_ballot_reg <= s_tdata[15:0];
            in_value_reg  <= s_tdata[47:16];
        end
    end

    // Step logic
    pdr_step u_step (
        .st      (st_reg),
        .cfg     (cfg),
        .cmd     (in_cmd_reg),
        .mb      (in_ballot_reg),
        .mv      (in_value_reg),
        .st_next (st_next),
        .res     (step_res)
    );

    // Decision state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase           <= PH_INIT;
            st_reg.ballot          <= BALLOT_NONE;
            st_reg.decision_value  <= VALUE_NONE;
            st_reg.promised_ballot <= BALLOT_NONE;
            st_reg.promised_value  <= VALUE_NONE;
            st_reg.promise_count   <= '0;
        end
        else if (step_go)
        begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.send_to_all, out_reg.send_type, out_reg.send_valid};
    assign m_tdata  = {5'b0, out_reg.chosen_value, out_reg.chosen_ballot,
                       out_reg.phase_now, out_reg.send_value, out_reg.send_ballot,
                       out_reg.send_dest};

endmodule

FILE: rtl/core/pdr_step.sv
// ----------------------------------------------------------------------------
// pdr_step
// Single-step transition logic: takes the decision state and one message,
// gives the next state and the result item of that step.
// ----------------------------------------------------------------------------
module pdr_step
    import pdr_pkg::*;
(
    input  pdr_state_t  st,
    input  pdr_cfg_t    cfg,
    input  cmd_t        cmd,
    input  ballot_t     mb,
    input  value_t      mv,
    output pdr_state_t  st_next,
    output pdr_result_t res
);

    count_t  cnt_sat;
    logic    higher;
    ballot_t pb_new;
    value_t  pv_new;
    logic    majority;
    ballot_t bal_fin;
    value_t  dv_fin;
    ballot_t bal_inc;

    // Promise bookkeeping
    assign cnt_sat  = (st.promise_count != COUNT_MAX) ? st.promise_count + 7'd1
                                                      : st.promise_count;
    assign higher   = (mb > st.promised_ballot);
    assign pb_new   = higher ? mb : st.promised_ballot;
    assign pv_new   = higher ? mv : st.promised_value;
    assign majority = ({cnt_sat, 1'b0} > NODE_COUNT);
    assign bal_fin  = (pb_new != BALLOT_NONE) ? pb_new : st.ballot;
    assign dv_fin   = (pb_new != BALLOT_NONE) ? pv_new : st.decision_value;

    // Saturating re-prepare ballot
    assign bal_inc  = (st.ballot != BALLOT_MAX) ? st.ballot + 16'sd1 : st.ballot;

    // Transition
    always_comb
    begin
        st_next = st;
        res     = '0;

        if (cmd == CMD_CLIENT)
        begin
            st_next.decision_value = mv;
        end
        else if (cmd <= CMD_TIMEOUT)
        begin
            unique case (st.phase)
                PH_INIT:
                begin
                    st_next.decision_value  = VALUE_NONE;
                    st_next.promised_ballot = BALLOT_NONE;
                    st_next.promised_value  = VALUE_NONE;
                    st_next.promise_count   = '0;
                    if (cfg.role == ROLE_ACCEPTOR)
                    begin
                        st_next.phase  = PH_WAIT_PREPARE;
                        st_next.ballot = BALLOT_NONE;
                    end
                    else
                    begin
                        st_next.phase    = PH_WAIT_PROMISE;
                        st_next.ballot   = mb;
                        res.send_valid   = 1'b1;
                        res.send_type    = MSG_PREPARE;
                        res.send_to_all  = 1'b1;
                        res.send_ballot  = mb;
                        res.send_value   = VALUE_NONE;
                    end
                end
                PH_WAIT_PREPARE:
                begin
                    if (cmd == CMD_PREPARE)
                    begin
                        st_next.phase           = PH_WAIT_ACCEPT;
                        st_next.promised_ballot = mb;
                        st_next.promised_value  = mv;
                        res.send_valid          = 1'b1;
                        res.send_type           = MSG_PROMISE;
                        res.send_dest           = cfg.leader_id;
                        res.send_ballot         = mb;
                        res.send_value          = mv;
                    end
                end
                PH_WAIT_PROMISE:
                begin
                    if (cmd == CMD_TIMEOUT)
                    begin
                        st_next.ballot  = bal_inc;
                        res.send_valid  = 1'b1;
                        res.send_type   = MSG_PREPARE;
                        res.send_to_all = 1'b1;
                        res.send_ballot = bal_inc;
                        res.send_value  = VALUE_NONE;
                    end
                    else if (cmd == CMD_PROMISE)
                    begin
                        st_next.promise_count   = cnt_sat;
                        st_next.promised_ballot = pb_new;
                        st_next.promised_value  = pv_new;
                        if (majority)
                        begin
                            st_next.phase          = PH_DECIDED;
                            st_next.ballot         = bal_fin;
                            st_next.decision_value = dv_fin;
                            res.send_valid         = 1'b1;
                            res.send_type          = MSG_ACCEPT;
                            res.send_to_all        = 1'b1;
                            res.send_ballot        = bal_fin;
                            res.send_value         = dv_fin;
                        end
                    end
                end
                PH_WAIT_ACCEPT:
                begin
                    if (cmd == CMD_PREPARE)
                    begin
                        if (higher)
                        begin
                            st_next.promised_ballot = mb;
                            st_next.promised_value  = mv;
                            res.send_valid          = 1'b1;
                            res.send_type           = MSG_PROMISE;
                            res.send_dest           = cfg.leader_id;
                            res.send_ballot         = mb;
                            res.send_value          = mv;
                        end
                    end
                    else if (cmd == CMD_ACCEPT)
                    begin
                        st_next.ballot         = mb;
                        st_next.decision_value = mv;
                        st_next.phase          = PH_DECIDED;
                    end
                end
                default:
                begin
                    // decided: every message is ignored
                end
            endcase
        end

        res.phase_now     = st_next.phase;
        res.chosen_ballot = st_next.ballot;
        res.chosen_value  = st_next.decision_value;
    end

endmodule

FILE: rtl/core/pdr_checker.sv
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level checks on the result stream of the decision role core.
// ----------------------------------------------------------------------------
module pdr_checker
    import pdr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [3:0]   m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No message: all send fields are zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tuser[3:1] == 3'd0 && m_tdata[55:0] == 56'd0)
        else $error("send fields not cleared without a message");

    // Multicast carries no destination
    a_mcast_dest: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tuser[3] |-> m_tdata[7:0] == 8'd0)
        else $error("multicast with a destination");

    // Prepare is multicast with no value
    a_prepare: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tuser[2:1] == MSG_PREPARE
        |-> m_tuser[3] && m_tdata[55:24] == VALUE_NONE)
        else $error("malformed prepare");

endmodule

bind paxos_decision_role_fsm_core pdr_checker u_pdr_checker (.*);
